// File: rtl/dwmf_pkg.sv
// ----------------------------------------------------------------------------
// dwmf_pkg
// Shared types and constants for the distinct window marker finder.
// ----------------------------------------------------------------------------
`default_nettype none

package dwmf_pkg;

   localparam int SYMBOL_BITS       = 8;
   localparam int WINDOW_BITS       = 5;
   localparam int MARKER_BITS       = 16;
   localparam int MAX_WINDOW_DEF    = 16;
   localparam int POSITION_BITS_DEF = 16;
   localparam int WINDOW_MIN        = 2;

   typedef logic [SYMBOL_BITS-1:0] symbol_type;
   typedef logic [WINDOW_BITS-1:0] window_type;
   typedef logic [MARKER_BITS-1:0] marker_type;

   localparam window_type WINDOW_RESET = window_type'(4);

endpackage

`default_nettype wire

// File: rtl/dwmf_cell.sv
// ----------------------------------------------------------------------------
// dwmf_cell
// One history byte: shifts toward the older end and compares with the new byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dwmf_cell
   import dwmf_pkg::*;
(
   input  wire        clock,
   input  wire        advance,
   input  wire        enable,
   input  symbol_type shift_in,
   input  symbol_type probe,
   output symbol_type shift_out,
   output logic       hit
);

   symbol_type byte_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= shift_in;
      end
   end

   assign shift_out = byte_ff;
   assign hit       = enable && (byte_ff == probe);

endmodule

`default_nettype wire

// File: rtl/dwmf_out_buf.sv
// ----------------------------------------------------------------------------
// dwmf_out_buf
// Output register with a skid entry between the core and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dwmf_out_buf
   import dwmf_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        in_valid,
   input  marker_type in_data,
   output logic       out_valid,
   output marker_type out_data,
   input  wire        out_stall,
   output logic       full
);

   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   marker_type out_data_ff;
   marker_type skid_data_ff;
   logic       load_out;
   logic       load_skid;

   always_comb begin
      load_out      = !out_valid_ff || !out_stall;
      load_skid     = 1'b0;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (load_out) begin
         out_valid_in  = skid_valid_ff || in_valid;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         load_skid     = 1'b1;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end
      if (load_skid) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

`default_nettype wire

// File: rtl/distinct_window_marker_finder_core.sv
// ----------------------------------------------------------------------------
// distinct_window_marker_finder_core
// Finds the first position where the last window_length bytes are distinct.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_stall  | req_symbol, req_end_of_buffer
//  rsp_     | out       | rsp_valid/rsp_stall  | rsp_marker_position
//  csr_     | in        | csr_valid/csr_ready  | csr_window_length
//
//  One byte per cycle while req_stall is low; the new byte is compared against all history cells at
//  once, and the next run length is computed combinationally from the run length register.
//  A result is registered in the output buffer (output register, or skid entry while rsp_stall is high).
//  Synchronous reset clears counters, flags and the output buffer; the
//  window length returns to 4.
//  req_stall rises only while the output register and skid entry both hold items.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_window_marker_finder_core
   import dwmf_pkg::*;
#(
   parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  symbol_type req_symbol,
   input  wire        req_end_of_buffer,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output marker_type rsp_marker_position,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  window_type csr_window_length
);

   localparam int RUN_BITS = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS = (RUN_BITS > WINDOW_BITS) ? RUN_BITS : WINDOW_BITS;

   window_type                 window_ff;
   logic [POSITION_BITS-1:0]   count_ff;
   logic [POSITION_BITS-1:0]   count_in;
   logic [RUN_BITS-1:0]        run_ff;
   logic [RUN_BITS-1:0]        run_in;
   logic                       reported_ff;
   logic                       reported_in;

   logic                       accept;
   logic                       buf_full;
   logic [CMP_BITS-1:0]        win_ext;
   logic [RUN_BITS-1:0]        win_eff;
   logic [RUN_BITS:0]          run_cand;
   logic [RUN_BITS-1:0]        run_new;
   logic [POSITION_BITS-1:0]   count_next;
   logic                       fire;
   logic                       res_valid;
   marker_type                 res_data;
   marker_type                 pos_out;

   logic       [MAX_WINDOW-1:0] hit;
   logic       [MAX_WINDOW-1:0] enable;
   symbol_type                  chain [MAX_WINDOW+1];

   assign accept    = req_valid && !req_stall;
   assign req_stall = buf_full;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         window_ff <= csr_window_length;
      end
   end

   always_comb begin
      win_ext = CMP_BITS'(window_ff);
      if (win_ext < CMP_BITS'(WINDOW_MIN)) begin
         win_ext = CMP_BITS'(WINDOW_MIN);
      end else if (win_ext > CMP_BITS'(MAX_WINDOW)) begin
         win_ext = CMP_BITS'(MAX_WINDOW);
      end
      win_eff = win_ext[RUN_BITS-1:0];
   end

   assign chain[0] = req_symbol;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      assign enable[i] = run_ff > RUN_BITS'(i);
      dwmf_cell u_cell (
         .clock     (clock),
         .advance   (accept),
         .enable    (enable[i]),
         .shift_in  (chain[i]),
         .probe     (req_symbol),
         .shift_out (chain[i+1]),
         .hit       (hit[i])
      );
   end

   always_comb begin
      run_cand = (RUN_BITS+1)'(run_ff) + (RUN_BITS+1)'(1);
      for (int i = MAX_WINDOW - 1; i >= 0; i--) begin
         if (hit[i]) begin
            run_cand = (RUN_BITS+1)'(i + 1);
         end
      end
      if (run_cand > (RUN_BITS+1)'(win_eff)) begin
         run_new = win_eff;
      end else begin
         run_new = run_cand[RUN_BITS-1:0];
      end
   end

   assign count_next = (count_ff == '1) ? count_ff : count_ff + POSITION_BITS'(1);

   if (POSITION_BITS >= MARKER_BITS) begin : g_pos_trunc
      assign pos_out = count_next[MARKER_BITS-1:0];
   end else begin : g_pos_ext
      assign pos_out = {{(MARKER_BITS-POSITION_BITS){1'b0}}, count_next};
   end

   assign fire      = !reported_ff && (run_new >= win_eff);
   assign res_valid = accept && (fire || (req_end_of_buffer && !reported_ff));
   assign res_data  = fire ? pos_out : '0;

   always_comb begin
      count_in    = count_ff;
      run_in      = run_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (req_end_of_buffer) begin
            count_in    = '0;
            run_in      = '0;
            reported_in = 1'b0;
         end else begin
            count_in    = count_next;
            run_in      = run_new;
            reported_in = reported_ff || fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         run_ff      <= '0;
         reported_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         run_ff      <= run_in;
         reported_ff <= reported_in;
      end
   end

   dwmf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_marker_position),
      .out_stall (rsp_stall),
      .full      (buf_full)
   );

endmodule

`default_nettype wire
